[design/vpa_pkg.sv]
package vpa_pkg;

    localparam int OWNER_ENTRIES_DEF = 16;
    localparam int FREE_ENTRIES_DEF  = 17;
    localparam int ADDR_BITS_DEF     = 16;

    localparam logic [15:0] TOTAL_SIZE_RST   = 16'd1024;
    localparam logic [15:0] MIN_FRAGMENT_RST = 16'd10;

    typedef enum logic [1:0] {
        REG_TOTAL_SIZE   = 2'd0,
        REG_FIT_POLICY   = 2'd1,
        REG_MIN_FRAGMENT = 2'd2
    } reg_index_t;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_FIT    = 3'd1;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic        operation;
        logic [15:0] alloc_size;
        logic [15:0] owner_id;
    } vpa_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] granted_id;
        logic [15:0] start_address;
        logic [15:0] granted_size;
    } vpa_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic latch;      // capture request, bump id on allocate
        logic init;       // reset tables
        logic own_clr;    // clear owner scan index
        logic own_step;   // examine one owner entry
        logic free_clr;   // clear free scan index
        logic free_step;  // examine one free entry
        logic commit;     // update tables and build result
    } vpa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_release;
        logic zero_size;
        logic own_last;
        logic own_hit;    // empty slot found (alloc) or id found (release)
        logic free_last;
    } vpa_sts_t;

endpackage

[design/vpa_ctrl.sv]
module vpa_ctrl
    import vpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     cfg_init,
    input  vpa_sts_t sts,
    output vpa_cmd_t cmd,
    output logic     busy,
    output logic     done
);

    typedef enum logic [2:0] {
        S_BOOT, S_IDLE, S_LATCH, S_OWN, S_FREE, S_COMMIT
    } state_t;

    state_t state_reg;
    logic   done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_BOOT:   state_reg <= S_IDLE;
                S_IDLE:   if (start && !done_reg) state_reg <= S_LATCH;
                S_LATCH:  state_reg <= S_OWN;
                S_OWN:
                begin
                    if (!sts.is_release && sts.zero_size)
                        state_reg <= S_COMMIT;
                    else if (sts.own_hit)
                        state_reg <= S_FREE;
                    else if (sts.own_last)
                        state_reg <= S_COMMIT;
                end
                S_FREE:   if (sts.free_last) state_reg <= S_COMMIT;
                S_COMMIT:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.init     = cfg_init || (state_reg == S_BOOT);
        cmd.latch    = (state_reg == S_IDLE) && start && !done_reg;
        cmd.own_clr  = (state_reg == S_LATCH);
        cmd.own_step = (state_reg == S_OWN) && !sts.own_hit && !sts.own_last
                       && !(!sts.is_release && sts.zero_size);
        cmd.free_clr = (state_reg == S_OWN);
        cmd.free_step = (state_reg == S_FREE);
        cmd.commit   = (state_reg == S_COMMIT);
    end

    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;

    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_COMMIT))
        else $error("done without commit");
    a_free_from_own: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FREE) && $past(state_reg != S_FREE) |-> $past(state_reg == S_OWN))
        else $error("free scan entered wrongly");
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done while not busy");

endmodule

[design/vpa_datapath.sv]
module vpa_datapath
    import vpa_pkg::*;
#(
    parameter int OWNER_ENTRIES = OWNER_ENTRIES_DEF,
    parameter int FREE_ENTRIES  = FREE_ENTRIES_DEF,
    parameter int ADDR_BITS     = ADDR_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  vpa_cmd_t    cmd,
    input  vpa_req_t    req,
    input  logic [15:0] total_size,
    input  logic [1:0]  fit_policy,
    input  logic [15:0] min_fragment,
    output vpa_sts_t    sts,
    output vpa_rsp_t    rsp
);

    localparam int OW = $clog2(OWNER_ENTRIES);
    localparam int FW = $clog2(FREE_ENTRIES);

    typedef logic [ADDR_BITS-1:0] addr_t;

    addr_t              free_start_reg  [FREE_ENTRIES];
    addr_t              free_length_reg [FREE_ENTRIES];
    logic [FREE_ENTRIES-1:0]  free_valid_reg;
    logic [15:0]        owner_tag_reg   [OWNER_ENTRIES];
    addr_t              owner_start_reg [OWNER_ENTRIES];
    addr_t              owner_length_reg[OWNER_ENTRIES];
    logic [OWNER_ENTRIES-1:0] owner_valid_reg;
    logic [15:0]        id_counter_reg;

    vpa_req_t           req_reg;
    logic [OW-1:0]      oi_reg;
    logic [FW-1:0]      fi_reg;
    logic               slot_ok_reg;
    logic [OW-1:0]      slot_reg;
    addr_t              addr_reg, size_reg;
    logic               pick_ok_reg, left_ok_reg, right_ok_reg, empty_ok_reg;
    logic [FW-1:0]      pick_reg, left_reg, right_reg, empty_reg;
    vpa_rsp_t           rsp_reg;

    logic [OW-1:0] oi;
    logic [FW-1:0] fi;
    logic          own_match;
    addr_t         req_sz, f_st, f_ln, f_end, end_addr;
    logic          better;

    assign oi = oi_reg;
    assign fi = fi_reg;
    assign req_sz = addr_t'(req_reg.alloc_size);
    assign own_match = req_reg.operation == OP_RELEASE
        ? (owner_valid_reg[oi] && owner_tag_reg[oi] == req_reg.owner_id)
        : !owner_valid_reg[oi];
    assign f_st = free_start_reg[fi];
    assign f_ln = free_length_reg[fi];
    assign f_end = f_st + f_ln;
    assign end_addr = addr_reg + size_reg;

    always_comb
    begin
        if (!pick_ok_reg)
            better = 1'b1;
        else if (fit_policy == POL_BEST && f_ln != free_length_reg[pick_reg])
            better = f_ln < free_length_reg[pick_reg];
        else if (fit_policy == POL_WORST && f_ln != free_length_reg[pick_reg])
            better = f_ln > free_length_reg[pick_reg];
        else
            better = f_st < free_start_reg[pick_reg];
    end

    assign sts.is_release = req_reg.operation == OP_RELEASE;
    assign sts.zero_size  = req_reg.alloc_size == 16'd0;
    assign sts.own_last   = oi_reg == OW'(OWNER_ENTRIES - 1);
    assign sts.own_hit    = own_match;
    assign sts.free_last  = fi_reg == FW'(FREE_ENTRIES - 1);
    assign rsp = rsp_reg;

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_valid_reg  <= FREE_ENTRIES'(1);
            owner_valid_reg <= '0;
            id_counter_reg  <= '0;
            oi_reg <= '0;
            fi_reg <= '0;
            slot_ok_reg <= 1'b0;
            pick_ok_reg <= 1'b0;
            left_ok_reg <= 1'b0;
            right_ok_reg <= 1'b0;
            empty_ok_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init)
            begin
                free_valid_reg  <= FREE_ENTRIES'(total_size != 16'd0);
                owner_valid_reg <= '0;
            end
            if (cmd.latch && req.operation == OP_ALLOC)
                id_counter_reg <= id_counter_reg + 16'd1;
            if (cmd.latch)
                pick_ok_reg <= 1'b0;
            if (cmd.own_clr)
            begin
                oi_reg <= '0;
                slot_ok_reg <= 1'b0;
            end
            if (cmd.own_step)
                oi_reg <= oi_reg + OW'(1);
            if (cmd.free_clr)
            begin
                fi_reg <= '0;
                slot_ok_reg <= own_match;
                pick_ok_reg <= 1'b0;
                left_ok_reg <= 1'b0;
                right_ok_reg <= 1'b0;
                empty_ok_reg <= 1'b0;
            end
            if (cmd.free_step)
            begin
                if (!sts.free_last)
                    fi_reg <= fi_reg + FW'(1);
                if (!free_valid_reg[fi])
                begin
                    if (!empty_ok_reg) empty_ok_reg <= 1'b1;
                end
                else if (!sts.is_release)
                begin
                    if (f_ln >= req_sz && better) pick_ok_reg <= 1'b1;
                end
                else if (!left_ok_reg && f_end == addr_reg)
                    left_ok_reg <= 1'b1;
                else if (!right_ok_reg && f_st == end_addr)
                    right_ok_reg <= 1'b1;
            end
            if (cmd.commit && slot_ok_reg)
            begin
                if (!sts.is_release)
                begin
                    if (pick_ok_reg)
                    begin
                        owner_valid_reg[slot_reg] <= 1'b1;
                        if (!(free_length_reg[pick_reg] - req_sz > addr_t'(min_fragment)))
                            free_valid_reg[pick_reg] <= 1'b0;
                    end
                end
                else
                begin
                    owner_valid_reg[slot_reg] <= 1'b0;
                    if (left_ok_reg && right_ok_reg)
                        free_valid_reg[right_reg] <= 1'b0;
                    else if (!left_ok_reg && !right_ok_reg && empty_ok_reg)
                        free_valid_reg[empty_reg] <= 1'b1;
                end
            end
        end
    end

    // payload registers and table contents
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            req_reg <= req;
        if (cmd.init)
        begin
            free_start_reg[0]  <= '0;
            free_length_reg[0] <= addr_t'(total_size);
        end
        if (cmd.free_clr)
        begin
            slot_reg <= oi;
            addr_reg <= owner_start_reg[oi];
            size_reg <= owner_length_reg[oi];
        end
        if (cmd.free_step && free_valid_reg[fi])
        begin
            if (!sts.is_release)
            begin
                if (f_ln >= req_sz && better) pick_reg <= fi;
            end
            else if (!left_ok_reg && f_end == addr_reg)
                left_reg <= fi;
            else if (!right_ok_reg && f_st == end_addr)
                right_reg <= fi;
        end
        if (cmd.free_step && !free_valid_reg[fi] && !empty_ok_reg)
            empty_reg <= fi;
        if (cmd.commit)
        begin
            rsp_reg.start_address <= '0;
            rsp_reg.granted_size  <= '0;
            if (!sts.is_release)
            begin
                rsp_reg.granted_id <= id_counter_reg;
                if (sts.zero_size)       rsp_reg.status <= ST_ZERO_SIZE;
                else if (!slot_ok_reg)   rsp_reg.status <= ST_FULL;
                else if (!pick_ok_reg)   rsp_reg.status <= ST_NO_FIT;
                else
                begin
                    rsp_reg.status <= ST_OK;
                    rsp_reg.start_address <= 16'(free_start_reg[pick_reg]);
                    owner_tag_reg[slot_reg]   <= id_counter_reg;
                    owner_start_reg[slot_reg] <= free_start_reg[pick_reg];
                    if (free_length_reg[pick_reg] - req_sz > addr_t'(min_fragment))
                    begin
                        rsp_reg.granted_size <= req_reg.alloc_size;
                        owner_length_reg[slot_reg] <= req_sz;
                        free_start_reg[pick_reg]  <= free_start_reg[pick_reg] + req_sz;
                        free_length_reg[pick_reg] <= free_length_reg[pick_reg] - req_sz;
                    end
                    else
                    begin
                        rsp_reg.granted_size <= 16'(free_length_reg[pick_reg]);
                        owner_length_reg[slot_reg] <= free_length_reg[pick_reg];
                    end
                end
            end
            else
            begin
                rsp_reg.granted_id <= req_reg.owner_id;
                if (!slot_ok_reg)
                    rsp_reg.status <= ST_NOT_FOUND;
                else
                begin
                    rsp_reg.status <= ST_OK;
                    rsp_reg.start_address <= 16'(addr_reg);
                    rsp_reg.granted_size  <= 16'(size_reg);
                    if (left_ok_reg)
                        free_length_reg[left_reg] <= right_ok_reg
                            ? free_length_reg[left_reg] + size_reg
                              + free_length_reg[right_reg]
                            : free_length_reg[left_reg] + size_reg;
                    else if (right_ok_reg)
                    begin
                        free_start_reg[right_reg]  <= addr_reg;
                        free_length_reg[right_reg] <= free_length_reg[right_reg] + size_reg;
                    end
                    else if (empty_ok_reg)
                    begin
                        free_start_reg[empty_reg]  <= addr_reg;
                        free_length_reg[empty_reg] <= size_reg;
                    end
                end
            end
        end
    end

    a_own_idx: assert property (@(posedge clk) disable iff (!rst_n)
        oi_reg <= OW'(OWNER_ENTRIES - 1))
        else $error("owner index out of range");
    a_free_idx: assert property (@(posedge clk) disable iff (!rst_n)
        fi_reg <= FW'(FREE_ENTRIES - 1))
        else $error("free index out of range");
    a_pick_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        pick_ok_reg |-> !sts.is_release)
        else $error("pick on release");

endmodule

[design/variable_partition_allocator_unit.sv]
// channel   direction  handshake                 payload
// request   in         start & !busy             vpa_req_t
// result    out        done, one cycle           vpa_rsp_t
// config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// a request strobes its result after these steps: latch, one step per owner
// entry up to the first hit, one per free entry, commit; the next request is
// taken only after the result strobes, so requests never overlap
// a zero-size allocate skips both scans, a miss in the owner table skips the
// free scan; busy stays high through the cycle the result strobes
// async active-low reset restores register defaults; the first cycle after
// reset loads one free block with busy high
// the result cannot be stalled: it is valid on done for one cycle only
module variable_partition_allocator_unit
    import vpa_pkg::*;
#(
    parameter int OWNER_ENTRIES = OWNER_ENTRIES_DEF,
    parameter int FREE_ENTRIES  = FREE_ENTRIES_DEF,
    parameter int ADDR_BITS     = ADDR_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  vpa_req_t    req,
    output logic        busy,
    output logic        done,
    output vpa_rsp_t    rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] total_size_reg, min_fragment_reg;
    logic [1:0]  fit_policy_reg;
    logic        cfg_we;
    logic        cfg_init;
    vpa_cmd_t    cmd;
    vpa_sts_t    sts;

    // config writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_we = cfg_valid && cfg_ready;
    // a total size write rebuilds the tables
    assign cfg_init = cfg_we && cfg_index == REG_TOTAL_SIZE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_size_reg   <= TOTAL_SIZE_RST;
            fit_policy_reg   <= POL_FIRST;
            min_fragment_reg <= MIN_FRAGMENT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TOTAL_SIZE:   total_size_reg   <= cfg_data;
                REG_FIT_POLICY:   fit_policy_reg   <= cfg_data[1:0];
                REG_MIN_FRAGMENT: min_fragment_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    vpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cfg_init (cfg_init),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    // table init uses the value being written
    vpa_datapath #(
        .OWNER_ENTRIES (OWNER_ENTRIES),
        .FREE_ENTRIES  (FREE_ENTRIES),
        .ADDR_BITS     (ADDR_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req          (req),
        .total_size   (cfg_init ? cfg_data : total_size_reg),
        .fit_policy   (fit_policy_reg),
        .min_fragment (min_fragment_reg),
        .sts          (sts),
        .rsp          (rsp)
    );

endmodule

[tb/variable_partition_allocator_unit_tb.sv]
module variable_partition_allocator_unit_tb;
    import vpa_pkg::*;

    localparam int OWN_N  = OWNER_ENTRIES_DEF;
    localparam int FREE_N = FREE_ENTRIES_DEF;

    logic        clk;
    logic        rst_n;
    logic        start;
    vpa_req_t    req;
    logic        busy;
    logic        done;
    vpa_rsp_t    rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    variable_partition_allocator_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .req(req), .busy(busy),
        .done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow allocator state
    logic [15:0] m_total;
    logic [1:0]  m_policy;
    logic [15:0] m_min_frag;
    logic [15:0] fr_start [FREE_N];
    logic [15:0] fr_len   [FREE_N];
    bit          fr_valid [FREE_N];
    logic [15:0] ow_tag   [OWN_N];
    logic [15:0] ow_start [OWN_N];
    logic [15:0] ow_len   [OWN_N];
    bit          ow_valid [OWN_N];
    logic [15:0] id_ctr;

    // requests waiting for the driver, each with its own pre-gap
    vpa_req_t    pending_reqs [$];
    int          pending_gaps [$];
    vpa_rsp_t    expected_rsps [$];
    int          err_count = 0;
    // live ids, so random releases mostly hit
    logic [15:0] live_ids [$];

    // driver handshake state
    int          gap_left = -1;
    bit          accepted = 0;

    always #5 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("variable_partition_allocator_unit_tb: done, errors");
        $finish;
    end

    function automatic void reset_tables();
        for (int i = 0; i < FREE_N; i++)
            fr_valid[i] = 0;
        for (int i = 0; i < OWN_N; i++)
            ow_valid[i] = 0;
        if (m_total != 0)
        begin
            fr_start[0] = 0;
            fr_len[0]   = m_total;
            fr_valid[0] = 1;
        end
    endfunction

    // does free entry c beat the current pick b under the policy
    function automatic bit fits_better(int c, int b);
        if (b < 0)
            return 1;
        if (m_policy == POL_BEST && fr_len[c] != fr_len[b])
            return fr_len[c] < fr_len[b];
        if (m_policy == POL_WORST && fr_len[c] != fr_len[b])
            return fr_len[c] > fr_len[b];
        return fr_start[c] < fr_start[b];
    endfunction

    function automatic vpa_rsp_t predict_alloc(logic [15:0] size);
        vpa_rsp_t r;
        int slot;
        int pick;
        slot = -1;
        pick = -1;
        id_ctr = id_ctr + 16'd1;
        r = '0;
        r.granted_id = id_ctr;
        if (size == 0)
        begin
            r.status = ST_ZERO_SIZE;
            return r;
        end
        for (int i = 0; i < OWN_N; i++)
            if (!ow_valid[i] && slot < 0)
                slot = i;
        if (slot < 0)
        begin
            r.status = ST_FULL;
            return r;
        end
        for (int i = 0; i < FREE_N; i++)
            if (fr_valid[i] && fr_len[i] >= size && fits_better(i, pick))
                pick = i;
        if (pick < 0)
        begin
            r.status = ST_NO_FIT;
            return r;
        end
        r.status        = ST_OK;
        r.start_address = fr_start[pick];
        if (fr_len[pick] - size > m_min_frag)
        begin
            r.granted_size = size;
            fr_start[pick] = fr_start[pick] + size;
            fr_len[pick]   = fr_len[pick] - size;
        end
        else
        begin
            r.granted_size = fr_len[pick];
            fr_valid[pick] = 0;
        end
        ow_tag[slot]   = id_ctr;
        ow_start[slot] = r.start_address;
        ow_len[slot]   = r.granted_size;
        ow_valid[slot] = 1;
        live_ids.push_back(id_ctr);
        return r;
    endfunction

    function automatic vpa_rsp_t predict_release(logic [15:0] id);
        vpa_rsp_t r;
        int slot;
        int lft;
        int rgt;
        int empty;
        logic [16:0] blk_end;
        slot  = -1;
        lft   = -1;
        rgt   = -1;
        empty = -1;
        r = '0;
        r.granted_id = id;
        for (int i = 0; i < OWN_N; i++)
            if (slot < 0 && ow_valid[i] && ow_tag[i] == id)
                slot = i;
        if (slot < 0)
        begin
            r.status = ST_NOT_FOUND;
            return r;
        end
        r.status        = ST_OK;
        r.start_address = ow_start[slot];
        r.granted_size  = ow_len[slot];
        ow_valid[slot]  = 0;
        blk_end = {1'b0, ow_start[slot]} + ow_len[slot];
        for (int i = 0; i < FREE_N; i++)
        begin
            if (!fr_valid[i])
            begin
                if (empty < 0)
                    empty = i;
            end
            else if (lft < 0 && {1'b0, fr_start[i]} + fr_len[i] == {1'b0, r.start_address})
                lft = i;
            else if (rgt < 0 && {1'b0, fr_start[i]} == blk_end)
                rgt = i;
        end
        if (lft >= 0)
        begin
            fr_len[lft] = fr_len[lft] + r.granted_size;
            if (rgt >= 0)
            begin
                fr_len[lft]   = fr_len[lft] + fr_len[rgt];
                fr_valid[rgt] = 0;
            end
        end
        else if (rgt >= 0)
        begin
            fr_start[rgt] = r.start_address;
            fr_len[rgt]   = fr_len[rgt] + r.granted_size;
        end
        else if (empty >= 0)
        begin
            fr_start[empty] = r.start_address;
            fr_len[empty]   = r.granted_size;
            fr_valid[empty] = 1;
        end
        for (int k = 0; k < live_ids.size(); k++)
            if (live_ids[k] == id)
            begin
                live_ids.delete(k);
                break;
            end
        return r;
    endfunction

    // queue a request for the driver; prediction happens on acceptance
    task automatic queue_req(logic op, logic [15:0] size, logic [15:0] id);
        vpa_req_t q;
        q.operation  = op;
        q.alloc_size = size;
        q.owner_id   = id;
        pending_reqs.push_back(q);
        pending_gaps.push_back(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5));
    endtask

    // wait until the block is idle and nothing is outstanding
    task automatic drain();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || busy)
            @(posedge clk);
        repeat (45) @(posedge clk);
    endtask

    // live ids are known only once earlier requests were accepted
    task automatic drain_light();
        while (pending_reqs.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_TOTAL_SIZE:
            begin
                m_total = val;
                reset_tables();
                live_ids.delete();
            end
            REG_FIT_POLICY:   m_policy = val[1:0];
            REG_MIN_FRAGMENT: m_min_frag = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // driver: one request per gap, changes only on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!start)
            begin
                if (pending_reqs.size() != 0)
                begin
                    if (gap_left < 0)
                        gap_left = pending_gaps[0];
                    if (gap_left == 0)
                    begin
                        req   <= pending_reqs[0];
                        start <= 1;
                        gap_left = -1;
                    end
                    else
                        gap_left--;
                end
            end
            else if (accepted)
            begin
                start <= 0;
            end
        end
    end

    // acceptance and result checking at the rising edge
    always @(posedge clk)
    begin
        vpa_rsp_t e;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: expected no result, actual %h", $time, rsp);
                    err_count++;
                end
                else
                begin
                    e = expected_rsps.pop_front();
                    if (rsp.status !== e.status || rsp.granted_id !== e.granted_id
                        || rsp.start_address !== e.start_address
                        || rsp.granted_size !== e.granted_size)
                    begin
                        $display("%0t: expected %0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d",
                                 $time, e.status, e.granted_id, e.start_address,
                                 e.granted_size, rsp.status, rsp.granted_id,
                                 rsp.start_address, rsp.granted_size);
                        err_count++;
                    end
                end
            end
            accepted = 0;
            if (start && !busy && pending_reqs.size() != 0)
            begin
                if (pending_reqs[0].operation == OP_ALLOC)
                    expected_rsps.push_back(predict_alloc(pending_reqs[0].alloc_size));
                else
                    expected_rsps.push_back(predict_release(pending_reqs[0].owner_id));
                void'(pending_reqs.pop_front());
                void'(pending_gaps.pop_front());
                accepted = 1;
            end
        end
    end

    function automatic logic [15:0] pick_live_id();
        if (live_ids.size() == 0)
            return id_ctr;
        return live_ids[$urandom_range(0, live_ids.size() - 1)];
    endfunction

    initial
    begin
        logic [15:0] sz;
        int n;
        clk       = 0;
        rst_n     = 0;
        start     = 0;
        req       = '0;
        cfg_valid = 0;
        cfg_index = REG_TOTAL_SIZE;
        cfg_data  = '0;
        m_total    = TOTAL_SIZE_RST;
        m_policy   = POL_FIRST;
        m_min_frag = MIN_FRAGMENT_RST;
        id_ctr     = 0;
        reset_tables();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: default settings, zero size, extremes, unknown id, table full
        queue_req(OP_ALLOC, 16'd0, 16'hFFFF);
        queue_req(OP_ALLOC, 16'hFFFF, 16'd0);
        queue_req(OP_RELEASE, 16'hFFFF, 16'hFFFF);
        queue_req(OP_RELEASE, 16'd0, 16'd0);
        queue_req(OP_ALLOC, 16'd100, 16'd0);
        queue_req(OP_ALLOC, 16'd1, 16'd0);
        queue_req(OP_RELEASE, 16'd0, 16'd5);
        for (int i = 0; i < 16; i++)
            queue_req(OP_ALLOC, 16'd20, 16'd0);
        drain();
        // owner table is now full with small blocks
        queue_req(OP_ALLOC, 16'd1, 16'd0);
        queue_req(OP_RELEASE, 16'd0, 16'd6);
        drain();

        write_reg(REG_TOTAL_SIZE, 16'hFFFF);
        write_reg(REG_FIT_POLICY, 16'(POL_BEST));
        write_reg(REG_MIN_FRAGMENT, 16'd0);
        queue_req(OP_ALLOC, 16'hFFFF, 16'd0);
        drain();
        write_reg(REG_TOTAL_SIZE, 16'd0);
        queue_req(OP_ALLOC, 16'd1, 16'd0);
        drain();
        write_reg(REG_MIN_FRAGMENT, 16'hFFFF);
        write_reg(REG_TOTAL_SIZE, 16'd1);
        queue_req(OP_ALLOC, 16'd1, 16'd0);
        drain();

        // random phases over settings, including the unused policy code
        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(REG_FIT_POLICY, 16'(ph % 4));
            write_reg(REG_MIN_FRAGMENT,
                      (ph == 5) ? 16'hFFFF : 16'($urandom_range(0, 40)));
            write_reg(REG_TOTAL_SIZE,
                      (ph == 7) ? 16'hFFFF : 16'($urandom_range(64, 2048)));
            n = 0;
            while (n < 160)
            begin
                if (pending_reqs.size() > 8)
                    @(posedge clk);
                else
                begin
                    case ($urandom_range(0, 9))
                        0: sz = 16'($urandom);
                        1: sz = 16'd0;
                        default: sz = 16'($urandom_range(1, 200));
                    endcase
                    if ($urandom_range(0, 1))
                        queue_req(OP_ALLOC, sz, 16'($urandom));
                    else if ($urandom_range(0, 7) == 0)
                        queue_req(OP_RELEASE, 16'($urandom), 16'($urandom));
                    else
                    begin
                        // needs predicted state, so let it settle first
                        drain_light();
                        queue_req(OP_RELEASE, 16'($urandom), pick_live_id());
                    end
                    n++;
                end
            end
            drain();
        end
        drain();
        if (err_count == 0)
            $display("variable_partition_allocator_unit_tb: done, clean");
        else
            $display("variable_partition_allocator_unit_tb: done, errors");
        $finish;
    end

endmodule

[filelist.f]
design/vpa_pkg.sv
design/vpa_ctrl.sv
design/vpa_datapath.sv
design/variable_partition_allocator_unit.sv
tb/variable_partition_allocator_unit_tb.sv
